// ===== rtl/core/vgpd_pkg.sv =====
`default_nettype none

package vgpd_pkg;

  // fixed field widths
  localparam int unsigned COORD_W = 32;
  localparam int unsigned INV_W   = 32;
  localparam int unsigned HASH_W  = 32;
  localparam int unsigned EPOCH_W = 8;
  localparam int unsigned AXES    = 3;
  localparam int unsigned OUT_USER_W = 3;

  // output tuser bit positions
  localparam int unsigned OUT_KEPT_BIT    = 0;
  localparam int unsigned OUT_FULL_BIT    = 1;
  localparam int unsigned OUT_CLAMPED_BIT = 2;

  // inverse spacing after reset is 1.0 in Q16.16
  localparam logic [INV_W-1:0] INV_RESET = 32'h0001_0000;

  // epoch marks, zero is the cleared mark
  localparam logic [EPOCH_W-1:0] EPOCH_FIRST = 8'd1;
  localparam logic [EPOCH_W-1:0] EPOCH_LAST  = 8'hFF;

  // spatial hash multipliers, x then y then z
  localparam logic [HASH_W-1:0] HASH_PRIME [AXES] = '{
    32'd73856093, 32'd19349663, 32'd83492791
  };

  // running hash and clamp flag handed along the axis cells
  typedef struct packed {
    logic [HASH_W-1:0] hash;
    logic              clamped;
  } vgpd_chain_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_INDEX,
    ST_MOD,
    ST_PROBE,
    ST_CHECK,
    ST_WRAP
  } vgpd_state_e;

endpackage

`default_nettype wire

// ===== rtl/core/voxel_grid_point_decimation_core.sv =====
// Voxel grid point decimation: passes on the first point that falls in each cell.
// Input stream carries one point per word: x, y, z in signed Q16.16 in tdata and
// a set start flag in tuser that empties the set of occupied cells first.
// Output stream echoes the point and reports kept, table full and index clamped
// in tuser; a word with kept low is a duplicate that a consumer drops.
// The inverse spacing register is to be written through cfg_we_i / cfg_wdata_i
// only while no point is in flight; the block itself does not enforce this.
// Zero passes every point with no table lookup. From accept a point goes through
// the states index, mod, probe and check; each further probe of linear probing
// stays in check. On the probing path a new point is taken in the cycle a result
// is handed to the output register, so points are worked on one at a time; the
// probe loop through the table RAM read port limits how fast they go through.
// After reset the table epoch marks are swept over all TABLE_ENTRIES slots, with
// s_axis_tready low; every 255th set start repeats that sweep before its point.
// When the receiver stalls the result waits in the output register; the next
// point is accepted and worked on, and it holds at its last step until the
// register is free.
`default_nettype none

module voxel_grid_point_decimation_core
  import vgpd_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES   = 1024,
  parameter int unsigned CELL_INDEX_BITS = 21
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  // configuration: inverse spacing
  input  wire logic                    cfg_we_i,
  input  wire logic [INV_W-1:0]        cfg_wdata_i,
  // input points
  input  wire logic                    s_axis_tvalid,
  output logic                         s_axis_tready,
  input  wire logic [AXES*COORD_W-1:0] s_axis_tdata,  // coord_x, coord_y, coord_z
  input  wire logic                    s_axis_tuser,  // set_start
  // result points
  output logic                         m_axis_tvalid,
  input  wire logic                    m_axis_tready,
  output logic      [AXES*COORD_W-1:0] m_axis_tdata,  // out_x, out_y, out_z
  output logic      [OUT_USER_W-1:0]   m_axis_tuser   // kept, table_full, index_clamped
);

  localparam int unsigned SLOT_W    = $clog2(TABLE_ENTRIES);
  localparam int unsigned KEY_W     = 3 * CELL_INDEX_BITS;
  localparam int unsigned WORD_W    = EPOCH_W + KEY_W;
  localparam int unsigned RED_SHIFT = HASH_W + SLOT_W;
  localparam logic [64:0] RED_MULT  = 65'(((64'd1 << RED_SHIFT) +
                                           64'(TABLE_ENTRIES) - 64'd1) /
                                          64'(TABLE_ENTRIES));
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(TABLE_ENTRIES - 1);

  vgpd_state_e state_q, state_d;

  logic [INV_W-1:0]         inv_q;
  logic [AXES*COORD_W-1:0]  coord_q;
  logic                     start_q;
  logic                     start_clr;
  logic [EPOCH_W-1:0]       epoch_q, epoch_d, epoch_inc;
  logic [SLOT_W-1:0]        clr_q, clr_d;
  logic [SLOT_W-1:0]        slot_q, slot_d, first_q, next_slot, probe_slot;
  logic                     first_ld;
  logic [HASH_W-1:0]        quot_q;
  logic                     quot_ld;
  logic [64:0]              red_prod;
  logic [47:0]              quot_mul;
  logic [HASH_W-1:0]        rem_full;
  logic                     in_ready, in_accept, adv;
  logic                     bypass;

  vgpd_chain_t              chain_c [AXES+1];
  logic [KEY_W-1:0]         key_c   [AXES+1];
  vgpd_chain_t              chain_fin;
  logic [KEY_W-1:0]         key_fin;

  logic                     ram_we, ram_re;
  logic [SLOT_W-1:0]        ram_waddr, ram_raddr;
  logic [WORD_W-1:0]        ram_wdata, ram_rdata;
  logic [EPOCH_W-1:0]       rd_epoch;
  logic [KEY_W-1:0]         rd_key;
  logic                     slot_free, key_match, wrapped;

  logic                     fin, fin_kept, fin_full, fin_clamp;
  logic                     out_free, out_load;
  logic                     out_valid_q;
  logic [AXES*COORD_W-1:0]  out_data_q;
  logic [OUT_USER_W-1:0]    out_user_q;

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_q <= INV_RESET;
    end else if (cfg_we_i) begin
      inv_q <= cfg_wdata_i;
    end
  end

  assign bypass = (inv_q == '0);

  // row of axis cells: index, clamp, hash term, then fold along the row
  assign chain_c[0] = '0;
  assign key_c[0]   = '0;

  for (genvar g = 0; g < AXES; g++) begin : g_cell
    vgpd_axis_cell #(
      .CELL_INDEX_BITS (CELL_INDEX_BITS)
    ) u_cell (
      .clk_i   (clk_i),
      .load_i  (in_accept),
      .adv_i   (adv),
      .coord_i (s_axis_tdata[g*COORD_W +: COORD_W]),
      .inv_i   (inv_q),
      .prime_i (HASH_PRIME[g]),
      .chain_i (chain_c[g]),
      .key_i   (key_c[g]),
      .chain_o (chain_c[g+1]),
      .key_o   (key_c[g+1])
    );
  end

  assign chain_fin = chain_c[AXES];
  assign key_fin   = key_c[AXES];

  // hash mod table size by reciprocal multiply; the quotient is registered and the remainder formed from it
  assign red_prod   = {33'b0, chain_fin.hash} * RED_MULT;
  assign quot_mul   = 48'(quot_q) * 48'(TABLE_ENTRIES);
  assign rem_full   = chain_fin.hash - quot_mul[HASH_W-1:0];
  assign probe_slot = rem_full[SLOT_W-1:0];
  assign next_slot  = (slot_q == SLOT_LAST) ? '0 : slot_q + SLOT_W'(1);

  // key table with epoch marks
  vgpd_ram #(
    .WIDTH (WORD_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign rd_epoch  = ram_rdata[WORD_W-1:KEY_W];
  assign rd_key    = ram_rdata[KEY_W-1:0];
  assign slot_free = (rd_epoch != epoch_q);
  assign key_match = (rd_key == key_fin);
  assign wrapped   = (next_slot == first_q);

  assign epoch_inc = start_q ? epoch_q + EPOCH_W'(1) : epoch_q;
  assign out_free  = ~out_valid_q | m_axis_tready;

  // control sequencer
  always_comb begin
    state_d   = state_q;
    in_ready  = (state_q == ST_IDLE);
    adv       = 1'b0;
    quot_ld   = 1'b0;
    first_ld  = 1'b0;
    slot_d    = slot_q;
    ram_re    = 1'b0;
    ram_raddr = slot_q;
    ram_we    = 1'b0;
    ram_waddr = slot_q;
    ram_wdata = {epoch_q, key_fin};
    fin       = 1'b0;
    fin_kept  = 1'b1;
    fin_full  = 1'b0;
    fin_clamp = 1'b0;
    epoch_d   = epoch_q;
    start_clr = 1'b0;
    clr_d     = clr_q;
    unique case (state_q)
      ST_INIT, ST_WRAP: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '0;
        clr_d     = clr_q + SLOT_W'(1);
        if (clr_q == SLOT_LAST) begin
          clr_d   = '0;
          state_d = (state_q == ST_INIT) ? ST_IDLE : ST_INDEX;
        end
      end
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          state_d = ST_INDEX;
        end
      end
      ST_INDEX: begin
        adv = 1'b1;
        if (start_q && (epoch_q == EPOCH_LAST)) begin
          epoch_d   = EPOCH_FIRST;
          start_clr = 1'b1;
          state_d   = ST_WRAP;
        end else if (bypass) begin
          fin = 1'b1;
          if (out_free) begin
            epoch_d   = epoch_inc;
            start_clr = 1'b1;
            state_d   = ST_IDLE;
          end
        end else begin
          epoch_d   = epoch_inc;
          start_clr = 1'b1;
          state_d   = ST_MOD;
        end
      end
      ST_MOD: begin
        quot_ld = 1'b1;
        state_d = ST_PROBE;
      end
      ST_PROBE: begin
        slot_d    = probe_slot;
        first_ld  = 1'b1;
        ram_re    = 1'b1;
        ram_raddr = probe_slot;
        state_d   = ST_CHECK;
      end
      ST_CHECK: begin
        fin_clamp = chain_fin.clamped;
        if (slot_free) begin
          fin    = 1'b1;
          ram_we = out_free;
        end else if (key_match) begin
          fin      = 1'b1;
          fin_kept = 1'b0;
        end else if (wrapped) begin
          fin      = 1'b1;
          fin_full = 1'b1;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = next_slot;
          slot_d    = next_slot;
        end
        if (fin && out_free) begin
          in_ready = 1'b1;
          state_d  = s_axis_tvalid ? ST_INDEX : ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign s_axis_tready = in_ready;
  assign in_accept     = s_axis_tvalid & in_ready;
  assign out_load      = fin & out_free;

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
      epoch_q <= EPOCH_FIRST;
      clr_q   <= '0;
      start_q <= 1'b0;
    end else begin
      state_q <= state_d;
      epoch_q <= epoch_d;
      clr_q   <= clr_d;
      if (in_accept) begin
        start_q <= s_axis_tuser;
      end else if (start_clr) begin
        start_q <= 1'b0;
      end
    end
  end

  // point and probe payload
  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
    if (first_ld) begin
      first_q <= slot_d;
    end
    if (quot_ld) begin
      quot_q <= HASH_W'(red_prod >> RED_SHIFT);
    end
    if (in_accept) begin
      coord_q <= s_axis_tdata;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q                  <= coord_q;
      out_user_q[OUT_KEPT_BIT]    <= fin_kept;
      out_user_q[OUT_FULL_BIT]    <= fin_full;
      out_user_q[OUT_CLAMPED_BIT] <= fin_clamp;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

`ifndef SYNTHESIS
  // points are taken only when idle or while the last probe retires
  a_ready_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> (state_q == ST_IDLE || state_q == ST_CHECK))
    else $error("input ready outside idle or check");

  // a result never overwrites one that is still waiting
  a_out_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!m_axis_tvalid || m_axis_tready))
    else $error("output register overwritten");

  // zero is the cleared mark and must never be the live epoch
  a_epoch_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    epoch_q != '0)
    else $error("live epoch is zero");

  // after an epoch wrap sweep the set restarts at the first epoch
  a_wrap_epoch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($past(state_q) == ST_WRAP && state_q == ST_INDEX) |-> epoch_q == EPOCH_FIRST)
    else $error("epoch not restarted after sweep");

  // probe slots stay inside the table
  a_slot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CHECK) |-> (32'(slot_q) < TABLE_ENTRIES))
    else $error("probe slot out of range");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/vgpd_ram.sv =====
`default_nettype none

module vgpd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port, holds while not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/core/vgpd_axis_cell.sv =====
`default_nettype none

module vgpd_axis_cell
  import vgpd_pkg::*;
#(
  parameter int unsigned CELL_INDEX_BITS = 21
) (
  input  wire logic                         clk_i,
  input  wire logic                         load_i,
  input  wire logic                         adv_i,
  input  wire logic [COORD_W-1:0]           coord_i,
  input  wire logic [INV_W-1:0]             inv_i,
  input  wire logic [HASH_W-1:0]            prime_i,
  input  wire vgpd_chain_t                  chain_i,
  input  wire logic [3*CELL_INDEX_BITS-1:0] key_i,
  output vgpd_chain_t                       chain_o,
  output logic      [3*CELL_INDEX_BITS-1:0] key_o
);

  localparam int unsigned B      = CELL_INDEX_BITS;
  localparam int unsigned PROD_W = 2 * COORD_W;

  logic [PROD_W:0]      prod_full;
  logic [PROD_W-1:0]    prod_q;
  logic [32-B:0]        upper_bits;
  logic                 in_range;
  logic [B-1:0]         sat_idx;
  logic [COORD_W-1:0]   sat_ext;
  logic [HASH_W-1:0]    term;
  logic [B-1:0]         idx_q;
  logic [HASH_W-1:0]    term_q;
  logic                 clamp_q;

  // signed coordinate times unsigned inverse spacing, exact Q32.32
  assign prod_full = {{(COORD_W + 1){coord_i[COORD_W-1]}}, coord_i} *
                     {{(COORD_W + 1){1'b0}}, inv_i};

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      prod_q <= prod_full[PROD_W-1:0];
    end
  end

  // floor is the upper word; saturate when the index sign bit and the bits above it differ
  assign upper_bits = prod_q[PROD_W-1:COORD_W+B-1];
  assign in_range   = (&upper_bits) | ~(|upper_bits);

  always_comb begin
    if (in_range) begin
      sat_idx = prod_q[COORD_W+B-1:COORD_W];
    end else if (prod_q[PROD_W-1]) begin
      sat_idx = {1'b1, {(B - 1){1'b0}}};
    end else begin
      sat_idx = {1'b0, {(B - 1){1'b1}}};
    end
  end

  // hash term on the 32-bit two's complement index
  assign sat_ext = {{(COORD_W - B){sat_idx[B-1]}}, sat_idx};
  assign term    = sat_ext * prime_i;

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      idx_q   <= sat_idx;
      term_q  <= term;
      clamp_q <= ~in_range;
    end
  end

  // fold into the running hash and shift this index into the key
  assign chain_o.hash    = chain_i.hash ^ term_q;
  assign chain_o.clamped = chain_i.clamped | clamp_q;
  assign key_o           = {key_i[2*B-1:0], idx_q};

endmodule

`default_nettype wire

// ===== tb/voxel_decimation_checker.sv =====
module voxel_decimation_checker
  import vgpd_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES   = 1024,
  parameter int unsigned CELL_INDEX_BITS = 21
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [INV_W-1:0]        cfg_wdata_i,
  input  logic                    s_axis_tvalid,
  input  logic                    s_axis_tready,
  input  logic [AXES*COORD_W-1:0] s_axis_tdata,  // coord_x, coord_y, coord_z
  input  logic                    s_axis_tuser,  // set_start
  input  logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  input  logic [AXES*COORD_W-1:0] m_axis_tdata,  // out_x, out_y, out_z
  input  logic [OUT_USER_W-1:0]   m_axis_tuser,  // kept, table_full, index_clamped
  output int                      mismatch_count_o,
  output int                      points_in_flight_o
);

  localparam int unsigned KEY_W = 3 * CELL_INDEX_BITS;
  localparam logic signed [31:0] CELL_MAX = (32'sd1 <<< (CELL_INDEX_BITS - 1)) - 32'sd1;
  localparam logic signed [31:0] CELL_MIN = -(32'sd1 <<< (CELL_INDEX_BITS - 1));
  localparam logic [31:0] HASH_MUL_X = 32'd73856093;
  localparam logic [31:0] HASH_MUL_Y = 32'd19349663;
  localparam logic [31:0] HASH_MUL_Z = 32'd83492791;
  localparam logic [31:0] SPACING_AFTER_RESET = 32'h0001_0000;
  localparam logic [7:0]  MARK_FIRST = 8'd1;

  // one predicted result word
  typedef struct packed {
    logic        kept;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic        full;
    logic        clamped;
  } point_verdict_t;

  // shadow of the spacing register and the occupied-cell set
  logic [INV_W-1:0] inv_spacing;
  logic [KEY_W-1:0] cell_key_store [TABLE_ENTRIES];
  logic [7:0]       slot_mark [TABLE_ENTRIES];
  logic [7:0]       live_mark;
  point_verdict_t   expected_points [$];
  int               mismatches;

  // floor(coord * inv / 2^32), saturated to the cell index range
  function automatic logic signed [31:0] cell_index(input logic [31:0] coord,
                                                    input logic [31:0] inv,
                                                    output logic sat);
    logic signed [63:0] prod;
    logic signed [31:0] idx;
    prod = $signed({{32{coord[31]}}, coord}) * $signed({32'd0, inv});
    idx  = prod[63:32];
    sat  = 1'b0;
    if (idx > CELL_MAX) begin
      sat = 1'b1;
      idx = CELL_MAX;
    end else if (idx < CELL_MIN) begin
      sat = 1'b1;
      idx = CELL_MIN;
    end
    return idx;
  endfunction

  // new set: bump the live mark, sweep all marks when it wraps
  function automatic void open_new_set();
    live_mark = live_mark + 8'd1;
    if (live_mark == 8'd0) begin
      foreach (slot_mark[i]) slot_mark[i] = 8'd0;
      live_mark = MARK_FIRST;
    end
  endfunction

  // look the point's cell up in the set, record it if new
  function automatic point_verdict_t decimate_point(input logic [AXES*COORD_W-1:0] pt,
                                                    input logic start);
    point_verdict_t     v;
    logic signed [31:0] gx, gy, gz;
    logic               sx, sy, sz;
    logic [KEY_W-1:0]   key;
    logic [31:0]        h;
    int unsigned        slot;
    int unsigned        n;
    logic               settled;
    v.x       = pt[31:0];
    v.y       = pt[63:32];
    v.z       = pt[95:64];
    v.kept    = 1'b1;
    v.full    = 1'b0;
    v.clamped = 1'b0;
    if (start) open_new_set();
    if (inv_spacing != '0) begin
      gx = cell_index(v.x, inv_spacing, sx);
      gy = cell_index(v.y, inv_spacing, sy);
      gz = cell_index(v.z, inv_spacing, sz);
      v.clamped = sx | sy | sz;
      key  = {gx[CELL_INDEX_BITS-1:0], gy[CELL_INDEX_BITS-1:0], gz[CELL_INDEX_BITS-1:0]};
      h    = ($unsigned(gx) * HASH_MUL_X) ^ ($unsigned(gy) * HASH_MUL_Y) ^
             ($unsigned(gz) * HASH_MUL_Z);
      slot = h % TABLE_ENTRIES;
      settled = 1'b0;
      // linear probing, upward with wrap
      for (n = 0; n < TABLE_ENTRIES && !settled; n++) begin
        if (slot_mark[slot] != live_mark) begin
          slot_mark[slot]      = live_mark;
          cell_key_store[slot] = key;
          settled              = 1'b1;
        end else if (cell_key_store[slot] == key) begin
          v.kept  = 1'b0;
          settled = 1'b1;
        end else begin
          slot = (slot + 1) % TABLE_ENTRIES;
        end
      end
      if (!settled) v.full = 1'b1;
    end
    return v;
  endfunction

  function automatic void note_mismatch(input string what, input logic [31:0] want,
                                        input logic [31:0] got);
    mismatches++;
    $display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
  endfunction

  // compare one result word with the oldest prediction
  function automatic void check_result();
    point_verdict_t want, got;
    got.kept    = m_axis_tuser[OUT_KEPT_BIT];
    got.full    = m_axis_tuser[OUT_FULL_BIT];
    got.clamped = m_axis_tuser[OUT_CLAMPED_BIT];
    got.x       = m_axis_tdata[31:0];
    got.y       = m_axis_tdata[63:32];
    got.z       = m_axis_tdata[95:64];
    if (expected_points.size() == 0) begin
      mismatches++;
      $display("%0t: result word with no point in flight, expected none, got %h %h",
               $time, m_axis_tdata, m_axis_tuser);
      return;
    end
    want = expected_points.pop_front();
    if (got.kept !== want.kept) note_mismatch("kept", want.kept, got.kept);
    if (got.x !== want.x) note_mismatch("out_x", want.x, got.x);
    if (got.y !== want.y) note_mismatch("out_y", want.y, got.y);
    if (got.z !== want.z) note_mismatch("out_z", want.z, got.z);
    if (got.full !== want.full) note_mismatch("table_full", want.full, got.full);
    if (got.clamped !== want.clamped)
      note_mismatch("index_clamped", want.clamped, got.clamped);
  endfunction

  // watch both channels and the register port
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_spacing = SPACING_AFTER_RESET;
      foreach (slot_mark[i]) slot_mark[i] = 8'd0;
      live_mark  = MARK_FIRST;
      mismatches = 0;
      expected_points.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) check_result();
      if (s_axis_tvalid && s_axis_tready)
        expected_points.insert(expected_points.size(),
                               decimate_point(s_axis_tdata, s_axis_tuser));
      if (cfg_we_i) inv_spacing = cfg_wdata_i;
    end
    mismatch_count_o   <= mismatches;
    points_in_flight_o <= expected_points.size();
  end

endmodule

// ===== tb/tb_top.sv =====
module tb_top;
  import vgpd_pkg::*;

  localparam int unsigned TABLE_ENTRIES   = 1024;
  localparam int unsigned CELL_INDEX_BITS = 21;
  localparam int unsigned CYCLE_LIMIT     = 4_000_000;
  localparam int unsigned MIN_SET_STARTS  = 270;
  localparam logic [31:0] SPACING_UNIT    = 32'h0001_0000;
  localparam logic [31:0] CORNER_COORD [6] = '{
    32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000,
    32'hFFFF_FFFF, 32'h0001_0000, 32'hFFFF_0000
  };

  logic                    clk_i;
  logic                    rst_ni;
  logic                    cfg_we_i;
  logic [INV_W-1:0]        cfg_wdata_i;
  logic                    s_axis_tvalid;
  logic                    s_axis_tready;
  logic [AXES*COORD_W-1:0] s_axis_tdata;   // coord_x, coord_y, coord_z
  logic                    s_axis_tuser;   // set_start
  logic                    m_axis_tvalid;
  logic                    m_axis_tready;
  logic [AXES*COORD_W-1:0] m_axis_tdata;   // out_x, out_y, out_z
  logic [OUT_USER_W-1:0]   m_axis_tuser;   // kept, table_full, index_clamped

  int   mismatch_count;
  int   points_in_flight;
  int   set_starts;
  logic tx_steady;
  logic rx_steady;
  int   fill_y [TABLE_ENTRIES];
  int   fill_z [TABLE_ENTRIES];

  voxel_grid_point_decimation_core #(
    .TABLE_ENTRIES  (TABLE_ENTRIES),
    .CELL_INDEX_BITS(CELL_INDEX_BITS)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  voxel_decimation_checker #(
    .TABLE_ENTRIES  (TABLE_ENTRIES),
    .CELL_INDEX_BITS(CELL_INDEX_BITS)
  ) u_checker (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .s_axis_tvalid     (s_axis_tvalid),
    .s_axis_tready     (s_axis_tready),
    .s_axis_tdata      (s_axis_tdata),
    .s_axis_tuser      (s_axis_tuser),
    .m_axis_tvalid     (m_axis_tvalid),
    .m_axis_tready     (m_axis_tready),
    .m_axis_tdata      (m_axis_tdata),
    .m_axis_tuser      (m_axis_tuser),
    .mismatch_count_o  (mismatch_count),
    .points_in_flight_o(points_in_flight)
  );

  // 12 unit clock
  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // offer one point word after a random gap, return at its handshake
  task automatic send_point(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                            input logic [COORD_W-1:0] z, input logic start);
    int unsigned gap;
    if ($urandom_range(0, 31) == 0) tx_steady = !tx_steady;
    gap = tx_steady ? 0 : $urandom_range(0, 16);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tdata  <= {z, y, x};
    s_axis_tuser  <= start;
    s_axis_tvalid <= 1'b1;
    if (start) set_starts++;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // stop sending and let every predicted word come out
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (points_in_flight != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_spacing(input logic [INV_W-1:0] value);
    cfg_wdata_i <= value;
    cfg_we_i    <= 1'b1;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // result side with random stalls
  initial begin : result_sink
    int unsigned stall;
    m_axis_tready <= 1'b0;
    rx_steady = 1'b0;
    @(posedge rst_ni);
    forever begin
      if ($urandom_range(0, 31) == 0) rx_steady = !rx_steady;
      stall = rx_steady ? 0 : $urandom_range(0, 16);
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
    end
  end

  // hang guard
  initial begin : watchdog
    int unsigned cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Verification failed");
    $finish;
  end

  initial begin : stimulus
    int          i, j, k, a, pick, kind, phase, phase_items, set_len;
    logic [31:0] spacing;
    logic [31:0] anchor [AXES];
    logic [31:0] pt [AXES];

    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_wdata_i   <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= 1'b0;
    tx_steady  = 1'b0;
    set_starts = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset spacing of 1.0: first point with no set start, duplicates, new set
    send_point(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0);
    send_point(32'h0000_8000, 32'h0000_0000, 32'h0000_0000, 1'b0);
    send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 1'b0);
    send_point(32'h7FFF_0001, 32'h8000_FFFF, 32'hFFFF_0000, 1'b0);
    send_point(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    send_point(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1);
    send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 1'b0);

    // zero spacing keeps everything, set start still empties the set
    wait_idle();
    write_spacing('0);
    send_point(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0);
    send_point(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0);
    send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1);

    // largest spacing: saturation at both ends and right at the limits
    wait_idle();
    write_spacing('1);
    send_point(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0);
    send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 1'b0);
    send_point(32'h7FFF_0000, 32'h8000_1000, 32'h0000_0001, 1'b0);
    send_point(32'h0010_0000, 32'h0000_0000, 32'h0000_0000, 1'b0);
    send_point(32'h0010_0001, 32'h0000_0000, 32'h0000_0000, 1'b0);
    send_point(32'h0000_0000, 32'hFFF0_0000, 32'h0000_0000, 1'b0);
    send_point(32'h0000_0000, 32'hFFEF_FFFF, 32'h0000_0000, 1'b0);

    // smallest nonzero spacing: every coordinate lands in cell 0 or -1
    wait_idle();
    write_spacing(32'h0000_0001);
    send_point(32'h1234_5678, 32'hEDCB_A987, 32'h0000_0000, 1'b1);
    send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 1'b0);
    send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b0);

    // fill the table with distinct cells, then probe it while full
    wait_idle();
    write_spacing(SPACING_UNIT);
    for (i = 0; i < TABLE_ENTRIES; i++) begin
      fill_y[i] = $urandom_range(0, 15) - 8;
      fill_z[i] = $urandom_range(0, 15) - 8;
      send_point({i[15:0], 16'($urandom)}, {fill_y[i][15:0], 16'($urandom)},
                 {fill_z[i][15:0], 16'($urandom)}, i == 0);
    end
    for (j = 0; j < 24; j++) begin
      if (j % 2 == 0) begin
        pick = 2048 + j;
        send_point({pick[15:0], 16'($urandom)}, $urandom, $urandom, 1'b0);
      end else begin
        pick = $urandom_range(0, TABLE_ENTRIES - 1);
        send_point({pick[15:0], 16'($urandom)}, {fill_y[pick][15:0], 16'($urandom)},
                   {fill_z[pick][15:0], 16'($urandom)}, 1'b0);
      end
    end

    // random sets, mostly single points, clustered around a moving anchor;
    // enough set starts to wrap the epoch mark
    foreach (anchor[a]) anchor[a] = $urandom;
    for (phase = 0; phase < 6 || set_starts < MIN_SET_STARTS; phase++) begin
      wait_idle();
      case (phase % 6)
        0:       spacing = SPACING_UNIT;
        1:       spacing = '0;
        2:       spacing = '1;
        3:       spacing = 32'h0000_0001;
        4:       spacing = $urandom_range(32'h0000_0100, 32'h0004_0000);
        default: spacing = $urandom;
      endcase
      write_spacing(spacing);
      phase_items = 0;
      while (phase_items < 60) begin
        set_len = ($urandom_range(0, 7) != 0) ? 1 : $urandom_range(2, 6);
        for (k = 0; k < set_len; k++) begin
          kind = $urandom_range(0, 9);
          for (a = 0; a < AXES; a++) begin
            case (kind)
              0, 1:    pt[a] = $urandom;
              2, 3, 4: pt[a] = anchor[a];
              5, 6, 7: pt[a] = anchor[a] + $urandom_range(0, 511) - 256;
              8:       pt[a] = CORNER_COORD[$urandom_range(0, 5)];
              default: begin
                pt[a] = $urandom >> $urandom_range(0, 31);
                if ($urandom_range(0, 1) != 0) pt[a] = -pt[a];
                anchor[a] = pt[a];
              end
            endcase
          end
          if ($urandom_range(0, 3) == 0) anchor = pt;
          send_point(pt[0], pt[1], pt[2], k == 0);
          phase_items++;
        end
      end
    end

    // drain and give the block time for any stray word
    wait_idle();
    repeat (32) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
